/* hw/rtl/tod_pkg.sv */
// Package for the time-of-day counter with alarms: record type, operation,
// target, unit and alarm codes, and the calendar limits.
// No dependencies.
package tod_pkg;

    localparam int unsigned SEC_W  = 6;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned DAY_W  = 4;
    localparam int unsigned STEP_W = 2;

    localparam logic [SEC_W:0]    SEC_WRAP   = 7'd60;
    localparam logic [SEC_W-1:0]  SEC_MAX    = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_MAX    = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_MAX   = 5'd23;
    localparam logic [DAY_W-1:0]  DAY_MAX    = 4'd6;
    localparam logic [DAY_W:0]    DAYS       = 5'd7;
    localparam logic [DAY_W-1:0]  DAY_ANY    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_RESET = 2'd2;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_INC  = 2'd1,
        FUNC_DEC  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        TGT_NOW    = 2'd0,
        TGT_ALARM1 = 2'd1,
        TGT_ALARM2 = 2'd2
    } target_t;

    typedef enum logic [2:0] {
        UNIT_SEC  = 3'd0,
        UNIT_MIN  = 3'd1,
        UNIT_HOUR = 3'd2,
        UNIT_DAY  = 3'd3,
        UNIT_ARM  = 3'd4
    } unit_t;

    typedef enum logic [1:0] {
        FIRED_NONE   = 2'd0,
        FIRED_ALARM1 = 2'd1,
        FIRED_ALARM2 = 2'd2
    } fired_t;

    typedef struct packed {
        logic [DAY_W-1:0]  wday;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  mins;
        logic [SEC_W-1:0]  secs;
    } rec_t;

endpackage

/* hw/rtl/time_of_day_counter_with_alarms.sv */
// Top level of the time-of-day counter with two alarms.
// Depends on tod_pkg.
//
// One beat is accepted per cycle while s_tready is high. It lands in the input register, and one
// pass through the carry chain and alarm compare loads the result register once the result side
// can advance, so the result is presented from the result register. The throughput of one beat
// per cycle is held as long as the result side takes a beat each cycle; a stalled result with the
// input register also full drops s_tready. The short carry chain runs over seconds, minutes, hours
// and weekday.
module time_of_day_counter_with_alarms
    import tod_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], target[3:2], unit[6:4], zero[7]
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // alarm_fired[1:0], now_seconds[7:2], now_minutes[13:8], now_hours[18:14],
    // now_weekday[21:19], day_changed[22], changed_day[26:23], zero[31:27]
    output logic [31:0] m_tdata
);

    logic              in_valid_reg;
    logic [1:0]        in_func_reg;
    logic [1:0]        in_target_reg;
    logic [2:0]        in_unit_reg;
    logic              m_valid_reg;
    logic [STEP_W-1:0] step_reg;
    rec_t              rec_reg [3];
    logic [1:0]        armed_reg;

    logic [1:0]        fired_reg;
    rec_t              now_reg;
    logic              day_chg_reg;
    logic [DAY_W-1:0]  chg_day_reg;

    logic              advance;
    logic              fire;

    logic [1:0]        idx;
    logic [2:0]        u;
    logic              do_inc;
    logic              do_dec;
    logic              do_tog;
    logic              arm_sel;
    rec_t              cur;
    rec_t              nxt;
    logic [SEC_W:0]    sec_sum;
    logic              c_min;
    logic              c_hour;
    logic              c_day;
    logic [DAY_W:0]    day_inc;
    rec_t              rec_next [3];
    logic [1:0]        armed_next;
    logic [1:0]        fired_next;
    logic              day_chg_next;
    logic [DAY_W-1:0]  chg_day_next;
    logic              match1;
    logic              match2;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_comb begin
        idx    = TGT_NOW;
        u      = in_unit_reg;
        do_inc = 1'b0;
        do_dec = 1'b0;
        do_tog = 1'b0;
        case (in_func_reg)
            FUNC_TICK: begin
                do_inc = 1'b1;
                u      = UNIT_SEC;
            end
            FUNC_INC: begin
                if (in_target_reg inside {TGT_NOW, TGT_ALARM1, TGT_ALARM2}) begin
                    idx = in_target_reg;
                    if (in_unit_reg inside {[UNIT_SEC:UNIT_DAY]}) begin
                        do_inc = 1'b1;
                    end else if (in_unit_reg == UNIT_ARM && in_target_reg != TGT_NOW) begin
                        do_tog = 1'b1;
                    end
                end
            end
            FUNC_DEC: begin
                if (in_target_reg inside {TGT_NOW, TGT_ALARM1, TGT_ALARM2}) begin
                    idx = in_target_reg;
                    if (in_unit_reg inside {[UNIT_SEC:UNIT_DAY]}) begin
                        do_dec = 1'b1;
                    end
                end
            end
            default: begin
                idx = TGT_NOW;
            end
        endcase

        cur     = rec_reg[idx];
        nxt     = cur;
        sec_sum = {1'b0, cur.secs} + {{(SEC_W + 1 - STEP_W){1'b0}}, step_reg};
        day_inc = {1'b0, cur.wday} + {{DAY_W{1'b0}}, 1'b1};
        c_min   = 1'b0;
        c_hour  = 1'b0;
        c_day   = 1'b0;

        if (do_inc) begin
            c_min  = (u == UNIT_SEC && sec_sum >= SEC_WRAP) || u == UNIT_MIN;
            c_hour = (c_min && cur.mins >= MIN_MAX) || u == UNIT_HOUR;
            c_day  = (c_hour && cur.hour >= HOUR_MAX) || u == UNIT_DAY;
            if (u == UNIT_SEC) begin
                nxt.secs = (sec_sum >= SEC_WRAP) ? '0 : sec_sum[SEC_W-1:0];
            end
            if (c_min) begin
                nxt.mins = (cur.mins >= MIN_MAX) ? '0 : cur.mins + 1'b1;
            end
            if (c_hour) begin
                nxt.hour = (cur.hour >= HOUR_MAX) ? '0 : cur.hour + 1'b1;
            end
            if (c_day) begin
                if (day_inc >= (DAYS << 1)) begin
                    nxt.wday = 4'(day_inc - (DAYS << 1));
                end else if (day_inc >= DAYS) begin
                    nxt.wday = 4'(day_inc - DAYS);
                end else begin
                    nxt.wday = day_inc[DAY_W-1:0];
                end
            end
        end else if (do_dec) begin
            c_min  = (u == UNIT_SEC && cur.secs == '0) || u == UNIT_MIN;
            c_hour = (c_min && cur.mins == '0) || u == UNIT_HOUR;
            c_day  = (c_hour && cur.hour == '0) || u == UNIT_DAY;
            if (u == UNIT_SEC) begin
                nxt.secs = (cur.secs == '0) ? SEC_MAX : cur.secs - 1'b1;
            end
            if (c_min) begin
                nxt.mins = (cur.mins == '0) ? MIN_MAX : cur.mins - 1'b1;
            end
            if (c_hour) begin
                nxt.hour = (cur.hour == '0) ? HOUR_MAX : cur.hour - 1'b1;
            end
            if (c_day) begin
                nxt.wday = (cur.wday == '0) ? DAY_MAX : cur.wday - 1'b1;
            end
        end

        for (int i = 0; i < 3; i++) begin
            rec_next[i] = rec_reg[i];
        end
        if (do_inc || do_dec) begin
            rec_next[idx] = nxt;
        end

        arm_sel    = (idx == TGT_ALARM2);
        armed_next = armed_reg;
        if (do_tog) begin
            armed_next[arm_sel] = !armed_reg[arm_sel];
        end

        match1 = armed_reg[0] && rec_reg[1].secs == rec_next[0].secs
                 && rec_reg[1].mins == rec_next[0].mins
                 && rec_reg[1].hour == rec_next[0].hour
                 && (rec_reg[1].wday == rec_next[0].wday || rec_reg[1].wday == DAY_ANY);
        match2 = armed_reg[1] && rec_reg[2].secs == rec_next[0].secs
                 && rec_reg[2].mins == rec_next[0].mins
                 && rec_reg[2].hour == rec_next[0].hour
                 && (rec_reg[2].wday == rec_next[0].wday || rec_reg[2].wday == DAY_ANY);

        fired_next = FIRED_NONE;
        if (in_func_reg == FUNC_TICK) begin
            if (match1) begin
                fired_next    = FIRED_ALARM1;
                armed_next[0] = 1'b0;
            end else if (match2) begin
                fired_next    = FIRED_ALARM2;
                armed_next[1] = 1'b0;
            end
        end

        day_chg_next = c_day;
        chg_day_next = c_day ? nxt.wday : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            step_reg     <= STEP_RESET;
            armed_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                rec_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                armed_reg <= armed_next;
                for (int i = 0; i < 3; i++) begin
                    rec_reg[i] <= rec_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg   <= s_tdata[1:0];
            in_target_reg <= s_tdata[3:2];
            in_unit_reg   <= s_tdata[6:4];
        end
        if (fire) begin
            fired_reg   <= fired_next;
            now_reg     <= rec_next[0];
            day_chg_reg <= day_chg_next;
            chg_day_reg <= chg_day_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, chg_day_reg, day_chg_reg, now_reg.wday[2:0], now_reg.hour,
                       now_reg.mins, now_reg.secs, fired_reg};

    a_no_fire_off_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_func_reg != FUNC_TICK |=> fired_reg == FIRED_NONE)
        else $error("alarm reported on an adjust beat");

    a_fired_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && fired_next == FIRED_ALARM1 |=> !armed_reg[0])
        else $error("alarm one still armed after firing");

    a_fired_disarms2: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && fired_next == FIRED_ALARM2 |=> !armed_reg[1])
        else $error("alarm two still armed after firing");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(armed_reg) && $stable(rec_reg[0]))
        else $error("state changed without a beat");

    a_now_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> now_reg.secs <= SEC_MAX && now_reg.mins <= MIN_MAX
                        && now_reg.hour <= HOUR_MAX && now_reg.wday <= DAY_MAX)
        else $error("current time out of range");

endmodule
